// ===== src/balpm_pkg.sv =====
// ----------------------------------------------------------------------------
// balpm_pkg
// Types and constants shared by the bus activity low-power manager.
// ----------------------------------------------------------------------------
`default_nettype none

package balpm_pkg;

	localparam int unsigned RATE_WINDOW_MS  = 1000;
	localparam int unsigned STANDALONE_RATE = 50;
	localparam int unsigned RATE_MAX        = 65535;

	localparam int unsigned IN_TDATA_W  = 168;
	localparam int unsigned OUT_TDATA_W = 40;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_STANDALONE_MODE     = 3'd0,
		CFG_WAKE_RATE_THRESHOLD = 3'd1,
		CFG_WATCH_TIME_MS       = 3'd2,
		CFG_HEALTH_TIMEOUT_MS   = 3'd3,
		CFG_AGGRESSIVE_SLEEP    = 3'd4
	} cfg_index_t;

	// last field in the lowest bits
	typedef struct packed {
		logic [1:0]  pad;
		logic        wake_edge;
		logic        radio_off;
		logic [3:0]  client_count;
		logic [31:0] drive_last_rx_ms;
		logic [31:0] chassis_last_rx_ms;
		logic [31:0] drive_frame_count;
		logic [31:0] chassis_frame_count;
		logic [31:0] now_ms;
	} tick_t;

	typedef struct packed {
		logic [1:0]  pad;
		logic        restart_radio;
		logic        tasks_parked;
		logic        transceiver_standby;
		logic        low_power;
		logic [15:0] drive_rate;
		logic [15:0] chassis_rate;
		logic        drive_bus_ok;
		logic        chassis_bus_ok;
	} status_t;

endpackage

`default_nettype wire

// ===== src/bus_activity_low_power_manager_unit.sv =====
// ----------------------------------------------------------------------------
// bus_activity_low_power_manager_unit
// Bus health, frame rates and watching/sleeping power control per service tick.
// ----------------------------------------------------------------------------
// One service tick is taken per clock cycle while the result is not stalled,
// and its status reaches m_tdata through the input register, which takes the
// tick on acceptance, and then the result register, which takes its status.
// The rate rests on the single state update loop: every tick reads and
// writes the sleep state, idle timer and rate snapshots in one update.
// Ticks may be presented back to back; a stalled result holds one tick in
// the input register before s_tready drops. Configuration writes are taken
// at once (cfg_ready is high) and should only be made with no tick in flight.
`default_nettype none

module bus_activity_low_power_manager_unit (
	input  wire                                     clk,
	input  wire                                     arst_n,
	// cfg_index selects the register, cfg_data holds its new value
	input  wire                                     cfg_valid,
	output logic                                    cfg_ready,
	input  wire  [balpm_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire  [balpm_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire                                     s_tvalid,
	output logic                                    s_tready,
	// now_ms, chassis_frame_count, drive_frame_count, chassis_last_rx_ms,
	// drive_last_rx_ms, client_count, radio_off, wake_edge, 2 bits zero
	input  wire  [balpm_pkg::IN_TDATA_W-1:0]        s_tdata,
	output logic                                    m_tvalid,
	input  wire                                     m_tready,
	// chassis_bus_ok, drive_bus_ok, chassis_rate, drive_rate, low_power,
	// transceiver_standby, tasks_parked, restart_radio, 2 bits zero
	output logic [balpm_pkg::OUT_TDATA_W-1:0]       m_tdata
);
	import balpm_pkg::*;

	// configuration
	logic        standalone_mode_q;
	logic [15:0] wake_rate_threshold_q;
	logic [31:0] watch_time_ms_q;
	logic [31:0] health_timeout_ms_q;
	logic        aggressive_sleep_q;

	// state
	logic        sleeping_q;
	logic [31:0] idle_since_ms_q;
	logic [31:0] last_rate_check_ms_q;
	logic [31:0] chassis_snapshot_q;
	logic [31:0] drive_snapshot_q;
	logic [15:0] chassis_fps_q;
	logic [15:0] drive_fps_q;
	logic        standby_q;
	logic        wake_pending_q;
	logic        parked_q;

	// pipeline
	logic        valid_s1;
	tick_t       tick_s1;
	logic        out_valid_q;
	status_t     out_data_q;
	logic        advance;

	// next-state values
	logic        window_due;
	logic [31:0] chassis_diff, drive_diff;
	logic [15:0] chassis_fps_n, drive_fps_n;
	logic        no_clients, active, idle_elapsed;
	logic        sleeping_n, standby_n, wake_pending_n, parked_n, restart_n;
	logic [31:0] idle_since_n;
	status_t     status_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			standalone_mode_q     <= 1'b0;
			wake_rate_threshold_q <= 16'd50;
			watch_time_ms_q       <= 32'd60000;
			health_timeout_ms_q   <= 32'd1000;
			aggressive_sleep_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_STANDALONE_MODE:     standalone_mode_q     <= cfg_data[0];
				CFG_WAKE_RATE_THRESHOLD: wake_rate_threshold_q <= cfg_data[15:0];
				CFG_WATCH_TIME_MS:       watch_time_ms_q       <= cfg_data;
				CFG_HEALTH_TIMEOUT_MS:   health_timeout_ms_q   <= cfg_data;
				CFG_AGGRESSIVE_SLEEP:    aggressive_sleep_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= tick_t'(s_tdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= status_n;
		end
	end

	// rate window: candidates are worked out in parallel with the old values
	assign window_due   = (tick_s1.now_ms - last_rate_check_ms_q) >= 32'(RATE_WINDOW_MS);
	assign chassis_diff = tick_s1.chassis_frame_count - chassis_snapshot_q;
	assign drive_diff   = tick_s1.drive_frame_count - drive_snapshot_q;

	always_comb begin
		chassis_fps_n = chassis_fps_q;
		drive_fps_n   = drive_fps_q;
		if (window_due) begin
			chassis_fps_n = (chassis_diff > 32'(RATE_MAX)) ? 16'(RATE_MAX) : chassis_diff[15:0];
			drive_fps_n   = (drive_diff > 32'(RATE_MAX)) ? 16'(RATE_MAX) : drive_diff[15:0];
		end
	end

	assign no_clients = (tick_s1.client_count == 4'd0) && !tick_s1.radio_off;
	assign active     = standalone_mode_q ? (drive_fps_n >= 16'(STANDALONE_RATE))
	                                      : (chassis_fps_n >= wake_rate_threshold_q);
	// a timer started on this tick has seen zero time
	assign idle_elapsed = (idle_since_ms_q == 32'd0) ? (watch_time_ms_q == 32'd0)
	                    : ((tick_s1.now_ms - idle_since_ms_q) >= watch_time_ms_q);

	always_comb begin
		sleeping_n     = sleeping_q;
		idle_since_n   = idle_since_ms_q;
		standby_n      = standby_q;
		parked_n       = parked_q;
		restart_n      = 1'b0;
		wake_pending_n = wake_pending_q || (standby_q && tick_s1.wake_edge);

		if (!sleeping_q) begin
			if (no_clients && !active) begin
				if (idle_since_ms_q == 32'd0) begin
					idle_since_n = tick_s1.now_ms;
				end
				if (idle_elapsed) begin
					sleeping_n = 1'b1;
					if (aggressive_sleep_q) begin
						if (!standby_q) begin
							standby_n      = 1'b1;
							wake_pending_n = 1'b0;
						end
						parked_n = 1'b1;
					end
				end
			end else begin
				idle_since_n = 32'd0;
			end
		end else begin
			if (aggressive_sleep_q) begin
				if (standby_q && wake_pending_n) begin
					standby_n      = 1'b0;
					wake_pending_n = 1'b0;
				end
			end else if (standby_q) begin
				standby_n      = 1'b0;
				wake_pending_n = 1'b0;
				parked_n       = 1'b0;
			end
			if (active) begin
				if (standby_n) begin
					standby_n      = 1'b0;
					wake_pending_n = 1'b0;
				end
				parked_n     = 1'b0;
				idle_since_n = 32'd0;
				sleeping_n   = 1'b0;
				restart_n    = 1'b1;
			end
		end
	end

	always_comb begin
		status_n                     = '0;
		status_n.chassis_bus_ok      = (tick_s1.chassis_last_rx_ms != 32'd0) &&
			((tick_s1.now_ms - tick_s1.chassis_last_rx_ms) <= health_timeout_ms_q);
		status_n.drive_bus_ok        = (tick_s1.drive_last_rx_ms != 32'd0) &&
			((tick_s1.now_ms - tick_s1.drive_last_rx_ms) <= health_timeout_ms_q);
		status_n.chassis_rate        = chassis_fps_n;
		status_n.drive_rate          = drive_fps_n;
		status_n.low_power           = sleeping_n;
		status_n.transceiver_standby = standby_n;
		status_n.tasks_parked        = parked_n;
		status_n.restart_radio       = restart_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleeping_q           <= 1'b0;
			idle_since_ms_q      <= '0;
			last_rate_check_ms_q <= '0;
			chassis_snapshot_q   <= '0;
			drive_snapshot_q     <= '0;
			chassis_fps_q        <= '0;
			drive_fps_q          <= '0;
			standby_q            <= 1'b0;
			wake_pending_q       <= 1'b0;
			parked_q             <= 1'b0;
		end else if (advance) begin
			sleeping_q      <= sleeping_n;
			idle_since_ms_q <= idle_since_n;
			chassis_fps_q   <= chassis_fps_n;
			drive_fps_q     <= drive_fps_n;
			standby_q       <= standby_n;
			wake_pending_q  <= wake_pending_n;
			parked_q        <= parked_n;
			if (window_due) begin
				last_rate_check_ms_q <= tick_s1.now_ms;
				chassis_snapshot_q   <= tick_s1.chassis_frame_count;
				drive_snapshot_q     <= tick_s1.drive_frame_count;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/balpm_checker.sv =====
// ----------------------------------------------------------------------------
// balpm_checker
// Port-level checks on the bus activity low-power manager.
// ----------------------------------------------------------------------------
`default_nettype none

module balpm_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 s_tready,
	input wire                                 m_tvalid,
	input wire                                 m_tready,
	input wire [balpm_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import balpm_pkg::*;

	status_t st;
	assign st = status_t'(m_tdata);

	// a held result must not change under the consumer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// with the result register empty a new request must be taken
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// standby and parking only happen while asleep
	a_standby_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (st.transceiver_standby || st.tasks_parked) |-> st.low_power)
		else $error("standby or parking outside sleep");

	// the radio restart marks the wake tick, which leaves everything awake
	a_restart_awake: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st.restart_radio |->
			!st.low_power && !st.transceiver_standby && !st.tasks_parked)
		else $error("restart pulse while still asleep");

endmodule

bind bus_activity_low_power_manager_unit balpm_checker u_balpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/balpm_status_checker.sv =====
// ----------------------------------------------------------------------------
// balpm_status_checker
// Watches the configuration, tick and status channels of the bus activity
// low-power manager, predicts the status of every accepted tick request and
// compares each accepted status against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module balpm_status_checker
	import balpm_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_valid,
	input  wire                    cfg_ready,
	input  wire  [CFG_INDEX_W-1:0] cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data,
	input  wire                    s_tvalid,
	input  wire                    s_tready,
	input  wire  [IN_TDATA_W-1:0]  s_tdata,
	input  wire                    m_tvalid,
	input  wire                    m_tready,
	input  wire  [OUT_TDATA_W-1:0] m_tdata,
	output int                     mismatches,
	output int                     outstanding
);

	// register copies
	logic        standalone;
	logic [15:0] wake_threshold;
	logic [31:0] watch_ms;
	logic [31:0] health_ms;
	logic        aggressive;

	// power state copy
	logic        asleep;
	logic [31:0] idle_start_ms;
	logic [31:0] rate_window_start_ms;
	logic [31:0] chassis_count_snap;
	logic [31:0] drive_count_snap;
	logic [15:0] chassis_fps;
	logic [15:0] drive_fps;
	logic        standby_on;
	logic        edge_latched;
	logic        parked;

	status_t status_q[$];

	function automatic logic [15:0] saturate_rate(logic [31:0] d);
		return (d > RATE_MAX) ? 16'(RATE_MAX) : d[15:0];
	endfunction

	// last == 0 means the bus was never heard
	function automatic logic heard_within(logic [31:0] now, logic [31:0] last);
		logic [31:0] age;
		age = now - last;
		return (last != 32'd0) && (age <= health_ms);
	endfunction

	// the edge latch only lives for one standby spell
	function automatic void change_standby(logic on);
		if (on != standby_on) begin
			standby_on   = on;
			edge_latched = 1'b0;
		end
	endfunction

	function automatic status_t predict_status(tick_t t);
		status_t     s;
		logic        no_clients;
		logic        busy;
		logic        restart;
		logic [31:0] since;
		restart = 1'b0;
		if (standby_on && t.wake_edge)
			edge_latched = 1'b1;

		since = t.now_ms - rate_window_start_ms;
		if (since >= RATE_WINDOW_MS) begin
			chassis_fps          = saturate_rate(t.chassis_frame_count - chassis_count_snap);
			drive_fps            = saturate_rate(t.drive_frame_count - drive_count_snap);
			chassis_count_snap   = t.chassis_frame_count;
			drive_count_snap     = t.drive_frame_count;
			rate_window_start_ms = t.now_ms;
		end

		// radio off counts as having clients
		no_clients = (t.client_count == 4'd0) && !t.radio_off;
		busy = standalone ? (drive_fps >= STANDALONE_RATE) : (chassis_fps >= wake_threshold);

		if (!asleep) begin
			if (no_clients && !busy) begin
				if (idle_start_ms == 32'd0)
					idle_start_ms = t.now_ms;
				since = t.now_ms - idle_start_ms;
				if (since >= watch_ms) begin
					asleep = 1'b1;
					if (aggressive) begin
						change_standby(1'b1);
						parked = 1'b1;
					end
				end
			end else begin
				idle_start_ms = 32'd0;
			end
		end else begin
			if (aggressive) begin
				if (standby_on && edge_latched)
					change_standby(1'b0);
			end else if (standby_on) begin
				change_standby(1'b0);
				parked = 1'b0;
			end
			if (busy) begin
				change_standby(1'b0);
				parked        = 1'b0;
				idle_start_ms = 32'd0;
				asleep        = 1'b0;
				restart       = 1'b1;
			end
		end

		s                     = '0;
		s.chassis_bus_ok      = heard_within(t.now_ms, t.chassis_last_rx_ms);
		s.drive_bus_ok        = heard_within(t.now_ms, t.drive_last_rx_ms);
		s.chassis_rate        = chassis_fps;
		s.drive_rate          = drive_fps;
		s.low_power           = asleep;
		s.transceiver_standby = standby_on;
		s.tasks_parked        = parked;
		s.restart_radio       = restart;
		return s;
	endfunction

	function automatic string differing_fields(status_t e, status_t g);
		string d;
		d = "";
		if (g.chassis_bus_ok !== e.chassis_bus_ok)           d = {d, " chassis_bus_ok"};
		if (g.drive_bus_ok !== e.drive_bus_ok)               d = {d, " drive_bus_ok"};
		if (g.chassis_rate !== e.chassis_rate)               d = {d, " chassis_rate"};
		if (g.drive_rate !== e.drive_rate)                   d = {d, " drive_rate"};
		if (g.low_power !== e.low_power)                     d = {d, " low_power"};
		if (g.transceiver_standby !== e.transceiver_standby) d = {d, " transceiver_standby"};
		if (g.tasks_parked !== e.tasks_parked)               d = {d, " tasks_parked"};
		if (g.restart_radio !== e.restart_radio)             d = {d, " restart_radio"};
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_t exp_status;
		status_t got_status;
		string   bad;
		if (!arst_n) begin
			standalone           = 1'b0;
			wake_threshold       = 16'd50;
			watch_ms             = 32'd60000;
			health_ms            = 32'd1000;
			aggressive           = 1'b0;
			asleep               = 1'b0;
			idle_start_ms        = '0;
			rate_window_start_ms = '0;
			chassis_count_snap   = '0;
			drive_count_snap     = '0;
			chassis_fps          = '0;
			drive_fps            = '0;
			standby_on           = 1'b0;
			edge_latched         = 1'b0;
			parked               = 1'b0;
			status_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STANDALONE_MODE:     standalone     = cfg_data[0];
					CFG_WAKE_RATE_THRESHOLD: wake_threshold = cfg_data[15:0];
					CFG_WATCH_TIME_MS:       watch_ms       = cfg_data;
					CFG_HEALTH_TIMEOUT_MS:   health_ms      = cfg_data;
					CFG_AGGRESSIVE_SLEEP:    aggressive     = cfg_data[0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready)
				status_q.push_back(predict_status(tick_t'(s_tdata)));

			if (m_tvalid && m_tready) begin
				got_status = status_t'(m_tdata);
				if (status_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: status %h with no tick outstanding", $realtime, m_tdata);
				end else begin
					exp_status = status_q.pop_front();
					bad = differing_fields(exp_status, got_status);
					if (bad != "") begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: status mismatch (%s ): expected %h, got %h",
								$realtime, bad, exp_status, got_status);
					end
				end
			end

			outstanding <= status_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bus activity low-power manager: a directed walk through
// sleep, standby, edge wake, traffic wake and the wrap cases, then random
// phases of modelled bus traffic under changing register settings, with
// random idling on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import balpm_pkg::*;

	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned PHASES       = 12;
	localparam int unsigned PHASE_TICKS  = 58;
	localparam int unsigned HOLD_CYCLES  = 64;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	cfg_index_t             cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	tick_t                  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int          mismatches;
	int          outstanding;
	int unsigned quiet_cycles;

	// traffic model and register shadows used to shape ticks
	logic [31:0] w_now;
	logic [31:0] w_chassis;
	logic [31:0] w_drive;
	logic        chassis_busy;
	logic        drive_busy;
	logic [31:0] cur_health;
	logic        gaps_on;
	logic        stalls_on;
	logic        long_hold;

	bus_activity_low_power_manager_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	balpm_status_checker status_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// status receiver: random stalls, plus one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
				m_tready <= 1'b1;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// leaves s_tvalid high; settle, or a random gap in the next call, lowers it
	task automatic send_tick(input tick_t t);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic tick(input logic [31:0] now, input logic [31:0] ccount,
			input logic [31:0] dcount, input logic [31:0] clast, input logic [31:0] dlast,
			input logic [3:0] clients, input logic roff, input logic wedge);
		tick_t t;
		t                     = '0;
		t.now_ms              = now;
		t.chassis_frame_count = ccount;
		t.drive_frame_count   = dcount;
		t.chassis_last_rx_ms  = clast;
		t.drive_last_rx_ms    = dlast;
		t.client_count        = clients;
		t.radio_off           = roff;
		t.wake_edge           = wedge;
		send_tick(t);
	endtask

	// stop offering and wait for every status to come back
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic configure(input logic [31:0] sa, input logic [31:0] thr,
			input logic [31:0] watch, input logic [31:0] health, input logic [31:0] aggr);
		logic [31:0] vals[5];
		vals = '{sa, thr, watch, health, aggr};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_index_t'(i);
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cur_health = health;
	endtask

	// last-frame times clustered around the health timeout boundary
	function automatic logic [31:0] recent_rx();
		case ($urandom_range(0, 7))
			0:       return 32'd0;
			1:       return $urandom;
			2:       return w_now - cur_health;
			3:       return w_now - cur_health - 32'd1;
			default: return w_now - $urandom_range(0, 2500);
		endcase
	endfunction

	function automatic tick_t next_tick();
		tick_t       t;
		logic [31:0] step;
		t = '0;
		// noise: every field random
		if ($urandom_range(0, 9) == 0) begin
			t.now_ms              = $urandom;
			t.chassis_frame_count = $urandom;
			t.drive_frame_count   = $urandom;
			t.chassis_last_rx_ms  = $urandom;
			t.drive_last_rx_ms    = $urandom;
			t.client_count        = 4'($urandom);
			t.radio_off           = 1'($urandom);
			t.wake_edge           = 1'($urandom);
			return t;
		end
		if ($urandom_range(0, 14) == 0) chassis_busy = ~chassis_busy;
		if ($urandom_range(0, 14) == 0) drive_busy = ~drive_busy;
		case ($urandom_range(0, 19))
			0:       step = $urandom;
			1:       step = 32'd0;
			2:       step = RATE_WINDOW_MS;
			default: step = $urandom_range(1, 700);
		endcase
		w_now += step;
		if ($urandom_range(0, 29) == 0)
			w_chassis = $urandom;
		else
			w_chassis += chassis_busy ? $urandom_range(30, 3000) : $urandom_range(0, 15);
		if ($urandom_range(0, 29) == 0)
			w_drive = $urandom;
		else
			w_drive += drive_busy ? $urandom_range(30, 3000) : $urandom_range(0, 15);

		t.now_ms              = w_now;
		t.chassis_frame_count = w_chassis;
		t.drive_frame_count   = w_drive;
		t.chassis_last_rx_ms  = recent_rx();
		t.drive_last_rx_ms    = recent_rx();
		t.client_count        = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
		t.radio_off           = ($urandom_range(0, 9) == 0);
		t.wake_edge           = ($urandom_range(0, 2) == 0);
		return t;
	endfunction

	initial begin
		logic [31:0] thr;
		logic [31:0] watch;
		logic [31:0] health;
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_STANDALONE_MODE;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		cur_health   = 32'd1000;
		gaps_on      = 1'b1;
		stalls_on    = 1'b1;
		long_hold    = 1'b0;
		chassis_busy = 1'b0;
		drive_busy   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings after reset: field extremes, time and counter wrap, radio off
		tick(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0);
		tick('1, '1, '1, '1, '1, 4'hF, 1'b1, 1'b1);
		tick(32'd1500, 32'd10, 32'd100, 32'd1000, 32'd0, 4'd0, 1'b0, 1'b0);
		tick(32'd1600, 32'd10, 32'd100, 32'd600, 32'd1600, 4'd0, 1'b1, 1'b0);
		tick(32'd1700, 32'd10, 32'd100, 32'd700, 32'd700, 4'd3, 1'b0, 1'b1);

		// aggressive sleep at once, zero health timeout
		settle();
		configure(32'd0, 32'd50, 32'd0, 32'd0, 32'd1);
		tick(32'd2600, 32'd10, 32'd100, 32'd2600, 32'd2599, 4'd0, 1'b0, 1'b0);
		tick(32'd2700, 32'd10, 32'd100, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0);
		tick(32'd2800, 32'd10, 32'd100, 32'd0, 32'd0, 4'd0, 1'b0, 1'b1);
		// standby already left: edge ignored, still parked
		tick(32'd2900, 32'd10, 32'd100, 32'd0, 32'd0, 4'd0, 1'b0, 1'b1);
		tick(32'd3700, 32'd5010, 32'd100, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0);
		tick(32'd4800, 32'd5010, 32'd100, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0);

		// aggressive cleared while on standby
		settle();
		configure(32'd0, 32'd50, 32'd0, 32'd0, 32'd0);
		tick(32'd4900, 32'd5010, 32'd100, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0);

		// standalone: fixed drive threshold, widest health timeout
		settle();
		configure(32'd1, 32'd65535, 32'd0, '1, 32'd0);
		tick(32'd5900, 32'd5010, 32'd149, 32'd1, 32'd5900, 4'd0, 1'b0, 1'b0);
		tick(32'd7000, 32'd5010, 32'd199, 32'd1, 32'd1, 4'd0, 1'b0, 1'b0);

		// idle timing that starts at time zero
		settle();
		configure(32'd0, 32'd50, 32'd100, 32'd1000, 32'd1);
		tick(32'd0, 32'd5010, 32'd199, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0);
		tick(32'd50, 32'd5010, 32'd199, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0);
		tick(32'd120, 32'd5010, 32'd199, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0);
		tick(32'd200, 32'd5010, 32'd199, 32'd0, 32'd0, 4'd0, 1'b0, 1'b0);
		tick(32'd300, 32'd5010, 32'd199, 32'd0, 32'd0, 4'd0, 1'b0, 1'b1);

		w_now     = 32'd300;
		w_chassis = 32'd5010;
		w_drive   = 32'd199;

		for (int p = 0; p < PHASES; p++) begin
			settle();
			if (p == 0) begin
				configure(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
			end else if (p == 1) begin
				configure('1, '1, '1, '1, '1);
			end else begin
				case ($urandom_range(0, 4))
					0:       thr = 32'd0;
					1:       thr = 32'd65535;
					2:       thr = 32'd50;
					3:       thr = $urandom_range(1, 300);
					default: thr = 32'($urandom_range(0, 65535));
				endcase
				case ($urandom_range(0, 5))
					0:       watch = 32'd0;
					1:       watch = '1;
					2:       watch = 32'd60000;
					default: watch = $urandom_range(1, 4000);
				endcase
				case ($urandom_range(0, 4))
					0:       health = 32'd0;
					1:       health = '1;
					2:       health = 32'd1000;
					3:       health = $urandom_range(1, 3000);
					default: health = $urandom;
				endcase
				// upper bits of narrow registers are random and must be dropped
				configure($urandom, ($urandom & 32'hFFFF_0000) | thr, watch, health, $urandom);
			end
			if (p == 3)
				long_hold = 1'b1;
			if (p >= PHASES - 2) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end
			for (int i = 0; i < PHASE_TICKS; i++)
				send_tick(next_tick());
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
